// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the RTL of the subscription table.
// Depends on nothing; files that assert include this header.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define SMT_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("smt assertion failed");

// Next-cycle implication, disabled while reset is high.
`define SMT_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("smt assertion failed");

`endif

// ===== rtl/smt_pkg.sv =====
// Package of the subscription table: item structs, operation codes,
// register indexes and reset values. Depends on nothing.
package smt_pkg;

  localparam int ID_W               = 16;
  localparam int CFG_IDX_W          = 3;
  localparam int NUM_SYS_IDS        = 4;
  localparam int ENTRIES_DEF        = 32;
  localparam int MSG_ID_BITS_DEF    = 16;
  localparam int CLIENT_ID_BITS_DEF = 16;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_ECHO_REQ   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ECHO_REPLY = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STOP_REQ   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TERM_REQ   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ALL_CLIENT = 3'd4;

  // Reset values of the configuration registers.
  localparam logic [ID_W-1:0] RST_ECHO_REQ   = 16'd1;
  localparam logic [ID_W-1:0] RST_ECHO_REPLY = 16'd2;
  localparam logic [ID_W-1:0] RST_STOP_REQ   = 16'd3;
  localparam logic [ID_W-1:0] RST_TERM_REQ   = 16'd4;
  localparam logic [ID_W-1:0] RST_ALL_CLIENT = 16'hFFFF;

  typedef enum logic [1:0] {
    OP_LOOKUP     = 2'd0,
    OP_INSERT     = 2'd1,
    OP_DEL_PAIR   = 2'd2,
    OP_DEL_CLIENT = 2'd3
  } smt_op_t;

  typedef struct packed {
    smt_op_t         operation;
    logic [ID_W-1:0] message_id;
    logic [ID_W-1:0] client_id;
    logic            publish;
  } smt_cmd_t;

  typedef struct packed {
    logic            ok;
    logic            publish_out;
    logic [ID_W-1:0] client_out;
    logic            system_default;
    logic            table_full;
  } smt_result_t;

endpackage

// ===== rtl/subscription_match_table.sv =====
// Subscription table with a parallel compare over all entries.
// Commands pass the input register, then the result register and strobe.
// Throughput: one item per cycle; busy is high only during reset.
// Reset clears every valid bit at once and loads the register defaults;
// there is no clearing pass. The receiver cannot stall results.
`include "assert_macros.svh"

module subscription_match_table #(
  parameter int ENTRIES        = smt_pkg::ENTRIES_DEF,
  parameter int MSG_ID_BITS    = smt_pkg::MSG_ID_BITS_DEF,
  parameter int CLIENT_ID_BITS = smt_pkg::CLIENT_ID_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  smt_pkg::smt_cmd_t              cmd,
  output logic                           done,
  output smt_pkg::smt_result_t           result,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [smt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [smt_pkg::ID_W-1:0]       cfg_data
);
  import smt_pkg::*;

  // Ids travel as 16 bits, so only the low min(param, 16) bits matter.
  localparam int MSG_W = (MSG_ID_BITS < ID_W) ? MSG_ID_BITS : ID_W;
  localparam int CLI_W = (CLIENT_ID_BITS < ID_W) ? CLIENT_ID_BITS : ID_W;

  logic [ID_W-1:0]    sys_id [NUM_SYS_IDS];
  logic [ID_W-1:0]    all_clients;

  logic               in_valid;
  smt_cmd_t           in_q;

  logic [ENTRIES-1:0] entry_valid;
  logic [MSG_W-1:0]   entry_message [ENTRIES];
  logic [CLI_W-1:0]   entry_client  [ENTRIES];
  logic               entry_publish [ENTRIES];

  logic [MSG_W-1:0]   mid;
  logic [CLI_W-1:0]   cid;
  logic [ENTRIES-1:0] hit;
  logic [ENTRIES-1:0] client_hit;
  logic [ENTRIES-1:0] free;
  logic [ENTRIES-1:0] free_first;
  logic [ENTRIES-1:0] valid_clr;
  logic [ENTRIES-1:0] valid_set;
  logic               any_hit;
  logic               is_sys;
  logic               hit_publish;
  logic [CLI_W-1:0]   hit_client;
  logic               ins_write;
  smt_result_t        result_next;

  assign busy      = rst;
  assign cfg_ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      sys_id[0]   <= RST_ECHO_REQ;
      sys_id[1]   <= RST_ECHO_REPLY;
      sys_id[2]   <= RST_STOP_REQ;
      sys_id[3]   <= RST_TERM_REQ;
      all_clients <= RST_ALL_CLIENT;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_ECHO_REQ:   sys_id[0]   <= cfg_data;
        CFG_ECHO_REPLY: sys_id[1]   <= cfg_data;
        CFG_STOP_REQ:   sys_id[2]   <= cfg_data;
        CFG_TERM_REQ:   sys_id[3]   <= cfg_data;
        CFG_ALL_CLIENT: all_clients <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q <= '0;
    end else if (start && !busy) begin
      in_q <= cmd;
    end
  end

  assign mid = in_q.message_id[MSG_W-1:0];
  assign cid = in_q.client_id[CLI_W-1:0];

  // Parallel compare. Inserts refuse duplicates, so at most one entry hits
  // a pair and the hit entry's fields can be gathered with a plain OR.
  always_comb begin
    hit_publish = 1'b0;
    hit_client  = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      client_hit[i] = entry_valid[i] && (entry_client[i] == cid);
      hit[i]        = client_hit[i] && (entry_message[i] == mid);
      hit_publish   = hit_publish | (hit[i] & entry_publish[i]);
      hit_client    = hit_client | (hit[i] ? entry_client[i] : '0);
    end
    is_sys = 1'b0;
    for (int r = 0; r < NUM_SYS_IDS; r++) begin
      is_sys = is_sys | (sys_id[r][MSG_W-1:0] == mid);
    end
  end

  assign any_hit    = |hit;
  assign free       = ~entry_valid;
  assign free_first = free & (~free + ENTRIES'(1));

  always_comb begin
    result_next = '0;
    valid_clr   = '0;
    ins_write   = 1'b0;
    unique case (in_q.operation)
      OP_LOOKUP: begin
        if (any_hit) begin
          result_next.ok          = 1'b1;
          result_next.publish_out = hit_publish;
          result_next.client_out  = ID_W'(hit_client);
        end else if (is_sys) begin
          result_next.ok             = 1'b1;
          result_next.publish_out    = 1'b1;
          result_next.client_out     = all_clients;
          result_next.system_default = 1'b1;
        end
      end
      OP_INSERT: begin
        if (!any_hit && !is_sys) begin
          if (|free) begin
            ins_write      = in_valid;
            result_next.ok = 1'b1;
          end else begin
            result_next.table_full = 1'b1;
          end
        end
      end
      OP_DEL_PAIR: begin
        valid_clr      = in_valid ? hit : '0;
        result_next.ok = any_hit;
      end
      OP_DEL_CLIENT: begin
        valid_clr      = in_valid ? client_hit : '0;
        result_next.ok = |client_hit;
      end
    endcase
  end

  assign valid_set = ins_write ? free_first : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
    end else begin
      entry_valid <= (entry_valid & ~valid_clr) | valid_set;
    end
  end

  // Entry payload, written at the lowest free entry.
  always_ff @(posedge clk) begin
    for (int i = 0; i < ENTRIES; i++) begin
      if (valid_set[i]) begin
        entry_message[i] <= mid;
        entry_client[i]  <= cid;
        entry_publish[i] <= in_q.publish;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid) begin
      result <= result_next;
    end
  end

  `SMT_ASSERT_NEXT(a_accept_to_valid, clk, rst, start && !busy, in_valid)
  `SMT_ASSERT_NOW(a_single_pair_hit, clk, rst, in_valid, $onehot0(hit))
  `SMT_ASSERT_NEXT(a_insert_fills, clk, rst, ins_write, |(entry_valid & $past(valid_set)))
  `SMT_ASSERT_NOW(a_default_is_ok, clk, rst, done && result.system_default, result.ok && result.publish_out)

endmodule

// ===== dv/smt_answer_checker.sv =====
`timescale 1ns / 100ps
// Checker for the subscription table: keeps its own copy of the table and registers,
// predicts the answer of every accepted command and compares each result strobe.
// Depends on smt_pkg for the command and result structs, op codes and register indexes.
module smt_answer_checker #(
  parameter int ENTRIES        = smt_pkg::ENTRIES_DEF,
  parameter int MSG_ID_BITS    = smt_pkg::MSG_ID_BITS_DEF,
  parameter int CLIENT_ID_BITS = smt_pkg::CLIENT_ID_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic                          busy,
  input  smt_pkg::smt_cmd_t             cmd,
  input  logic                          done,
  input  smt_pkg::smt_result_t          result,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [smt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [smt_pkg::ID_W-1:0]      cfg_data,
  output int                            fail_count,
  output int                            pending,
  output int                            defaults_seen,
  output int                            full_seen
);
  import smt_pkg::*;

  localparam logic [ID_W-1:0] MSG_MASK =
    (MSG_ID_BITS >= ID_W) ? {ID_W{1'b1}} : ({ID_W{1'b1}} >> (ID_W - MSG_ID_BITS));
  localparam logic [ID_W-1:0] CLI_MASK =
    (CLIENT_ID_BITS >= ID_W) ? {ID_W{1'b1}} : ({ID_W{1'b1}} >> (ID_W - CLIENT_ID_BITS));

  logic            ent_valid [ENTRIES];
  logic [ID_W-1:0] ent_msg   [ENTRIES];
  logic [ID_W-1:0] ent_cli   [ENTRIES];
  logic            ent_pub   [ENTRIES];
  logic [ID_W-1:0] sys_id    [NUM_SYS_IDS];
  logic [ID_W-1:0] all_clients;

  smt_result_t answer_q [$];
  int errors   = 0;
  int defaults = 0;
  int fulls    = 0;

  initial begin
    fail_count    = 0;
    pending       = 0;
    defaults_seen = 0;
    full_seen     = 0;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("[%0t] mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
    errors++;
  endtask

  function automatic int find_pair(input logic [ID_W-1:0] mid, input logic [ID_W-1:0] cid);
    for (int i = 0; i < ENTRIES; i++)
      if (ent_valid[i] && ent_msg[i] == mid && ent_cli[i] == cid) return i;
    return -1;
  endfunction

  function automatic logic is_system_msg(input logic [ID_W-1:0] mid);
    for (int r = 0; r < NUM_SYS_IDS; r++)
      if ((sys_id[r] & MSG_MASK) == mid) return 1'b1;
    return 1'b0;
  endfunction

  // Applies one command to the shadow table and returns the answer it should give.
  function automatic smt_result_t predict_answer(input smt_cmd_t c);
    smt_result_t     ans;
    logic [ID_W-1:0] mid;
    logic [ID_W-1:0] cid;
    int              hit;
    int              slot;
    ans  = '0;
    mid  = c.message_id & MSG_MASK;
    cid  = c.client_id & CLI_MASK;
    hit  = find_pair(mid, cid);
    slot = -1;
    case (c.operation)
      OP_LOOKUP: begin
        if (hit >= 0) begin
          ans.ok          = 1'b1;
          ans.publish_out = ent_pub[hit];
          ans.client_out  = ent_cli[hit];
        end else if (is_system_msg(mid)) begin
          ans.ok             = 1'b1;
          ans.publish_out    = 1'b1;
          ans.client_out     = all_clients;
          ans.system_default = 1'b1;
        end
      end
      OP_INSERT: begin
        if (hit < 0 && !is_system_msg(mid)) begin
          // The lowest free index is taken.
          for (int i = 0; i < ENTRIES; i++)
            if (!ent_valid[i] && slot < 0) slot = i;
          if (slot < 0) begin
            ans.table_full = 1'b1;
          end else begin
            ent_valid[slot] = 1'b1;
            ent_msg[slot]   = mid;
            ent_cli[slot]   = cid;
            ent_pub[slot]   = c.publish;
            ans.ok          = 1'b1;
          end
        end
      end
      OP_DEL_PAIR: begin
        if (hit >= 0) begin
          ent_valid[hit] = 1'b0;
          ans.ok         = 1'b1;
        end
      end
      default: begin
        for (int i = 0; i < ENTRIES; i++)
          if (ent_valid[i] && ent_cli[i] == cid) begin
            ent_valid[i] = 1'b0;
            ans.ok       = 1'b1;
          end
      end
    endcase
    return ans;
  endfunction

  always @(posedge clk) begin
    smt_result_t want;
    if (rst) begin
      for (int i = 0; i < ENTRIES; i++) ent_valid[i] = 1'b0;
      sys_id[0]   = RST_ECHO_REQ;
      sys_id[1]   = RST_ECHO_REPLY;
      sys_id[2]   = RST_STOP_REQ;
      sys_id[3]   = RST_TERM_REQ;
      all_clients = RST_ALL_CLIENT;
      answer_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_ECHO_REQ:   sys_id[0]   = cfg_data;
          CFG_ECHO_REPLY: sys_id[1]   = cfg_data;
          CFG_STOP_REQ:   sys_id[2]   = cfg_data;
          CFG_TERM_REQ:   sys_id[3]   = cfg_data;
          CFG_ALL_CLIENT: all_clients = cfg_data;
          default: ;
        endcase
      end
      if (start && !busy) begin
        want = predict_answer(cmd);
        answer_q.push_back(want);
        if (want.system_default) defaults++;
        if (want.table_full) fulls++;
      end
      if (done) begin
        if (answer_q.size() == 0) begin
          report_mismatch("result with no command waiting", 32'(result.client_out), 32'd0);
        end else begin
          want = answer_q.pop_front();
          if (result.ok !== want.ok)
            report_mismatch("ok", 32'(result.ok), 32'(want.ok));
          if (result.publish_out !== want.publish_out)
            report_mismatch("publish_out", 32'(result.publish_out),
                            32'(want.publish_out));
          if (result.client_out !== want.client_out)
            report_mismatch("client_out", 32'(result.client_out),
                            32'(want.client_out));
          if (result.system_default !== want.system_default)
            report_mismatch("system_default", 32'(result.system_default),
                            32'(want.system_default));
          if (result.table_full !== want.table_full)
            report_mismatch("table_full", 32'(result.table_full),
                            32'(want.table_full));
        end
      end
    end
    fail_count    <= errors;
    pending       <= answer_q.size();
    defaults_seen <= defaults;
    full_seen     <= fulls;
  end

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps
// Top of the subscription table testbench: clock, reset, command and register stimulus
// and the verdict. Depends on smt_pkg, the block and smt_answer_checker.
module tb_top;
  import smt_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int PHASES       = 8;
  localparam int PHASE_ITEMS  = 154;
  localparam int MSG_POOL     = 8;
  localparam int CLI_POOL     = 6;

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 start     = 1'b0;
  smt_cmd_t             cmd       = '0;
  logic                 cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [ID_W-1:0]      cfg_data  = '0;
  logic                 busy;
  logic                 done;
  smt_result_t          result;
  logic                 cfg_ready;

  int fail_count;
  int pending;
  int defaults_seen;
  int full_seen;

  int cycle_count = 0;
  int items_sent  = 0;
  int reg_writes  = 0;
  int sender_idle = 0;

  logic [ID_W-1:0] cur_sys [NUM_SYS_IDS];
  logic [ID_W-1:0] msg_pool [MSG_POOL];
  logic [ID_W-1:0] cli_pool [CLI_POOL];

  always #5 clk = ~clk;

  subscription_match_table u_top (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .cmd       (cmd),
    .done      (done),
    .result    (result),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  smt_answer_checker u_check (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .cmd           (cmd),
    .done          (done),
    .result        (result),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .fail_count    (fail_count),
    .pending       (pending),
    .defaults_seen (defaults_seen),
    .full_seen     (full_seen)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count, pending);
      $display("simulation failed");
      $finish;
    end
  end

  // Holds start high until the item is taken, then maybe leaves a gap.
  task automatic issue(input smt_op_t op, input logic [ID_W-1:0] mid,
                       input logic [ID_W-1:0] cid, input logic pub);
    start <= 1'b1;
    cmd   <= '{operation: op, message_id: mid, client_id: cid, publish: pub};
    do @(posedge clk); while (busy);
    items_sent++;
    if ($urandom_range(99) < sender_idle) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  // Waits until every answer is back.
  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (2) @(posedge clk);
  endtask

  // Leaves cfg_valid high; the caller lowers it after the last write of a set.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [ID_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    reg_writes++;
  endtask

  task automatic load_settings(input logic [ID_W-1:0] s0, input logic [ID_W-1:0] s1,
                               input logic [ID_W-1:0] s2, input logic [ID_W-1:0] s3,
                               input logic [ID_W-1:0] all_id);
    cur_sys[0] = s0;
    cur_sys[1] = s1;
    cur_sys[2] = s2;
    cur_sys[3] = s3;
    write_reg(CFG_ECHO_REQ, s0);
    write_reg(CFG_ECHO_REPLY, s1);
    write_reg(CFG_STOP_REQ, s2);
    write_reg(CFG_TERM_REQ, s3);
    write_reg(CFG_ALL_CLIENT, all_id);
    cfg_valid <= 1'b0;
  endtask

  task automatic build_pools();
    for (int i = 0; i < MSG_POOL; i++) msg_pool[i] = ID_W'($urandom);
    msg_pool[5] = $urandom_range(1) ? {ID_W{1'b1}} : '0;
    msg_pool[6] = cur_sys[$urandom_range(NUM_SYS_IDS - 1)];
    msg_pool[7] = cur_sys[$urandom_range(NUM_SYS_IDS - 1)];
    for (int i = 0; i < CLI_POOL; i++) cli_pool[i] = ID_W'($urandom);
    cli_pool[CLI_POOL-1] = $urandom_range(1) ? {ID_W{1'b1}} : '0;
  endtask

  initial begin
    int      insert_pct;
    int      w;
    smt_op_t op;
    logic [ID_W-1:0] s0;
    cur_sys[0] = RST_ECHO_REQ;
    cur_sys[1] = RST_ECHO_REPLY;
    cur_sys[2] = RST_STOP_REQ;
    cur_sys[3] = RST_TERM_REQ;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed commands against the reset register values.
    sender_idle = 30;
    issue(OP_LOOKUP, 16'h1234, 16'h0042, 1'b1);     // empty table, ordinary id
    issue(OP_LOOKUP, RST_ECHO_REQ, 16'h0000, 1'b0); // system default
    issue(OP_LOOKUP, RST_TERM_REQ, 16'hFFFF, 1'b0);
    issue(OP_INSERT, RST_ECHO_REPLY, 16'h0007, 1'b0); // system ids are never stored
    issue(OP_INSERT, 16'h0000, 16'h0000, 1'b0);
    issue(OP_INSERT, 16'hFFFF, 16'hFFFF, 1'b1);
    issue(OP_INSERT, 16'hFFFF, 16'hFFFF, 1'b0);     // duplicate pair
    issue(OP_LOOKUP, 16'h0000, 16'h0000, 1'b1);
    issue(OP_LOOKUP, 16'hFFFF, 16'hFFFF, 1'b0);
    issue(OP_LOOKUP, 16'hFFFF, 16'h0000, 1'b0);
    issue(OP_INSERT, 16'h00FF, 16'hFFFF, 1'b1);
    issue(OP_INSERT, 16'hFF00, 16'hFFFF, 1'b0);
    issue(OP_INSERT, 16'h5555, 16'hAAAA, 1'b1);
    issue(OP_DEL_PAIR, 16'h5555, 16'hAAAA, 1'b0);
    issue(OP_DEL_PAIR, 16'h5555, 16'hAAAA, 1'b0);   // already gone
    issue(OP_DEL_PAIR, RST_STOP_REQ, 16'h1111, 1'b0); // system id, no stored pair to delete
    issue(OP_INSERT, 16'hAAAA, 16'h5555, 1'b1);     // reuses the freed entry
    issue(OP_LOOKUP, 16'hAAAA, 16'h5555, 1'b0);
    issue(OP_DEL_CLIENT, 16'h1234, 16'hFFFF, 1'b1); // removes three entries
    issue(OP_LOOKUP, 16'hFFFF, 16'hFFFF, 1'b0);
    issue(OP_DEL_CLIENT, 16'h0000, 16'hFFFF, 1'b0); // nothing left for that client
    issue(OP_DEL_CLIENT, 16'hFFFF, 16'h0000, 1'b0);
    issue(OP_LOOKUP, 16'h0000, 16'h0000, 1'b0);

    for (int ph = 0; ph < PHASES; ph++) begin
      drain();
      if (ph == 0) begin
        // Writes past the last register must change nothing.
        for (int idx = CFG_ALL_CLIENT + 1; idx < (1 << CFG_IDX_W); idx++)
          write_reg(CFG_IDX_W'(idx), ID_W'($urandom));
        cfg_valid <= 1'b0;
      end else if (ph == 1) begin
        load_settings(16'h0000, 16'hFFFF, 16'h8000, 16'h7FFF, 16'h0000);
      end else if (ph == PHASES - 1) begin
        load_settings(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF);
      end else begin
        s0 = ID_W'($urandom);
        load_settings(s0, $urandom_range(2) == 0 ? s0 : ID_W'($urandom), ID_W'($urandom),
                      ID_W'($urandom), ID_W'($urandom));
      end
      build_pools();
      case (ph % 3)
        0:       sender_idle = 0;
        1:       sender_idle = 65;
        default: sender_idle = 12;
      endcase
      insert_pct = (ph % 2 == 0) ? 50 : 35;

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(99) < 12) begin
          issue(smt_op_t'($urandom_range(3)), ID_W'($urandom), ID_W'($urandom),
                1'($urandom_range(1)));
        end else begin
          w = $urandom_range(99);
          if (w < insert_pct) op = OP_INSERT;
          else if (w < insert_pct + 35) op = OP_LOOKUP;
          else if (w < insert_pct + 45) op = OP_DEL_PAIR;
          else op = OP_DEL_CLIENT;
          issue(op, msg_pool[$urandom_range(MSG_POOL - 1)],
                cli_pool[$urandom_range(CLI_POOL - 1)], 1'($urandom_range(1)));
        end
      end
    end

    drain();
    repeat (4) @(posedge clk);
    $display("ran %0d commands in %0d phases with %0d register writes",
             items_sent, PHASES, reg_writes);
    $display("answers included %0d system defaults and %0d full-table refusals",
             defaults_seen, full_seen);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("simulation failed");
    end
    $finish;
  end

endmodule
